// ----- hw/rtl/wbla_pkg.sv -----
package wbla_pkg;

    localparam int RING_DEPTH  = 1800;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SAMPLE_W    = 16;
    localparam int PERIOD_W    = 16;
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int QUO_W       = 16;
    localparam int STEP_W      = $clog2(QUO_W);
    localparam int FRAC_W      = QUO_W + 1;
    localparam int WSEL_W      = 3;
    localparam int CFG_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(2000);
    localparam logic [FRAC_W-1:0]   FULL_LOAD    = FRAC_W'(65536);

    typedef enum logic [0:0] {
        REG_WINDOW_SELECT,
        REG_SAMPLE_PERIOD
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE,
        BK_SUM,
        BK_MUL,
        BK_CHK,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] busy;
        logic [PERIOD_W-1:0] period;
        logic [CNT_W-1:0]    wlen;
    } item_t;

    function automatic logic [CNT_W-1:0] window_length(input logic [WSEL_W-1:0] code);
        int n;
        case (code)
            3'd0:    n = 30;
            3'd1:    n = 150;
            3'd2:    n = 450;
            3'd3:    n = 900;
            default: n = 1800;
        endcase
        if (n > RING_DEPTH)
            n = RING_DEPTH;
        return CNT_W'(n);
    endfunction

endpackage

// ----- hw/rtl/wbla_front.sv -----
module wbla_front
    import wbla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              busy_req,
    input  logic              q_full,
    output logic              push,
    output item_t             push_item
);

    logic [WSEL_W-1:0]   window_select_reg;
    logic [PERIOD_W-1:0] sample_period_reg;
    logic [SAMPLE_W-1:0] busy_ticks_reg, busy_ticks_next;
    logic [PERIOD_W-1:0] period_ticks_reg, period_ticks_next;

    logic [PERIOD_W-1:0] period_eff;
    logic [SAMPLE_W-1:0] busy_inc;
    logic [PERIOD_W:0]   count;
    logic                close;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_select_reg <= '0;
            sample_period_reg <= RESET_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SELECT: window_select_reg <= cfg_wdata[WSEL_W-1:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata[PERIOD_W-1:0];
                default:           ;
            endcase
        end
    end

    assign period_eff = (sample_period_reg == '0) ? PERIOD_W'(1) : sample_period_reg;
    assign busy_inc   = busy_ticks_reg + SAMPLE_W'(busy_req);
    assign count      = (PERIOD_W+1)'(period_ticks_reg) + (PERIOD_W+1)'(1);
    assign close      = count >= (PERIOD_W+1)'(period_eff);
    assign in_stall   = q_full;
    assign accept     = in_valid && !in_stall;
    assign push       = accept && close;

    assign push_item.busy   = busy_inc;
    assign push_item.period = period_eff;
    assign push_item.wlen   = window_length(window_select_reg);

    always_comb
    begin
        busy_ticks_next   = busy_ticks_reg;
        period_ticks_next = period_ticks_reg;
        if (accept)
        begin
            if (close)
            begin
                busy_ticks_next   = '0;
                period_ticks_next = '0;
            end
            else
            begin
                busy_ticks_next   = busy_inc;
                period_ticks_next = count[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_ticks_reg   <= '0;
            period_ticks_reg <= '0;
        end
        else
        begin
            busy_ticks_reg   <= busy_ticks_next;
            period_ticks_reg <= period_ticks_next;
        end
    end

endmodule

// ----- hw/rtl/wbla_queue.sv -----
module wbla_queue
    import wbla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/wbla_back.sv -----
module wbla_back
    import wbla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  item_t               pop_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FRAC_W-1:0]   load_fraction,
    output logic [CNT_W-1:0]    samples_used,
    output logic [SAMPLE_W-1:0] period_busy
);

    back_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]    wlen_reg;
    logic [IDX_W-1:0]    wslot_reg;
    logic [CNT_W-1:0]    filled_reg;
    logic [SUM_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_len_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                acc_valid_reg;
    logic [SUM_W-1:0]    denom_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic                sat_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic [FRAC_W-1:0]   frac_out_reg;
    logic [CNT_W-1:0]    used_out_reg;
    logic [SAMPLE_W-1:0] busy_out_reg;

    logic                mem_we;
    logic                mem_re;
    logic                sum_issue;
    logic                out_load;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    old_addr;
    logic [IDX_W-1:0]    sum_addr;
    logic [CNT_W-1:0]    filled_inc;
    logic [CNT_W-1:0]    used_calc;
    logic                same_window;
    logic [SUM_W-1:0]    total_inc;
    logic [SUM_W-1:0]    product;
    logic [SUM_W:0]      rem_shift;
    logic                div_bit;

    function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] x);
        logic [CNT_W:0] y;
        y = (x >= (CNT_W+1)'(RING_DEPTH)) ? x - (CNT_W+1)'(RING_DEPTH) : x;
        return y[IDX_W-1:0];
    endfunction

    assign old_addr = ring_wrap((CNT_W+1)'(wslot_reg) + (CNT_W+1)'(RING_DEPTH)
                                - (CNT_W+1)'(wlen_reg));
    assign sum_addr = ring_wrap((CNT_W+1)'(wslot_reg) + (CNT_W+1)'(RING_DEPTH - 1)
                                - (CNT_W+1)'(k_reg));

    assign filled_inc  = (filled_reg < CNT_W'(RING_DEPTH)) ? filled_reg + 1'b1 : filled_reg;
    assign used_calc   = (wlen_reg < filled_inc) ? wlen_reg : filled_inc;
    assign same_window = wlen_reg == total_len_reg;
    assign total_inc   = total_reg + SUM_W'(sample_reg)
                         - ((filled_reg >= wlen_reg) ? SUM_W'(rd_data_reg) : '0);
    assign product     = SUM_W'(used_reg) * SUM_W'(period_reg);
    assign rem_shift   = {rem_reg, 1'b0};
    assign div_bit     = rem_shift >= (SUM_W+1)'(denom_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (!q_empty) state_next = BK_READ;
            BK_READ:  state_next = BK_WRITE;
            BK_WRITE: state_next = same_window ? BK_MUL : BK_SUM;
            BK_SUM:   if (k_reg == used_reg && !acc_valid_reg) state_next = BK_MUL;
            BK_MUL:   state_next = BK_CHK;
            BK_CHK:   state_next = (total_reg >= denom_reg) ? BK_OUT : BK_DIV;
            BK_DIV:   if (step_reg == STEP_W'(QUO_W - 1)) state_next = BK_OUT;
            BK_OUT:   if (!out_valid_reg) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        sum_issue = 1'b0;
        out_load  = 1'b0;
        rd_addr   = old_addr;
        case (state_reg)
            BK_IDLE:  pop = !q_empty;
            BK_WRITE: mem_we = 1'b1;
            BK_SUM:
            begin
                sum_issue = k_reg < used_reg;
                rd_addr   = sum_addr;
            end
            BK_OUT:   out_load = !out_valid_reg;
            default:  ;
        endcase
    end

    assign mem_re = (state_reg == BK_READ) || sum_issue;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wslot_reg] <= sample_reg;
        if (mem_re)
            rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg <= pop_item.busy;
            period_reg <= pop_item.period;
            wlen_reg   <= pop_item.wlen;
        end
        if (state_reg == BK_WRITE)
            used_reg <= used_calc;
        if (state_reg == BK_MUL)
            denom_reg <= product;
        if (state_reg == BK_CHK)
        begin
            sat_reg  <= total_reg >= denom_reg;
            rem_reg  <= total_reg;
            step_reg <= '0;
        end
        if (state_reg == BK_DIV)
        begin
            rem_reg  <= div_bit ? SUM_W'(rem_shift - (SUM_W+1)'(denom_reg))
                                : rem_shift[SUM_W-1:0];
            quo_reg  <= {quo_reg[QUO_W-2:0], div_bit};
            step_reg <= step_reg + 1'b1;
        end
        if (out_load)
        begin
            frac_out_reg <= sat_reg ? FULL_LOAD : FRAC_W'(quo_reg);
            used_out_reg <= used_reg;
            busy_out_reg <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wslot_reg     <= '0;
            filled_reg    <= '0;
            total_reg     <= '0;
            total_len_reg <= window_length('0);
            k_reg         <= '0;
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_WRITE)
            begin
                wslot_reg  <= (wslot_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wslot_reg + 1'b1;
                filled_reg <= filled_inc;
                k_reg      <= '0;
                acc_valid_reg <= 1'b0;
                if (same_window)
                    total_reg <= total_inc;
                else
                begin
                    total_reg     <= '0;
                    total_len_reg <= wlen_reg;
                end
            end
            if (state_reg == BK_SUM)
            begin
                total_reg     <= total_reg + (acc_valid_reg ? SUM_W'(rd_data_reg) : '0);
                acc_valid_reg <= sum_issue;
                if (sum_issue)
                    k_reg <= k_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign load_fraction = frac_out_reg;
    assign samples_used  = used_out_reg;
    assign period_busy   = busy_out_reg;

`ifndef NO_ASSERTIONS
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count above ring depth");

    a_wslot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wslot_reg < IDX_W'(RING_DEPTH))
        else $error("write slot outside ring");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_MUL |-> used_reg != '0 && used_reg <= filled_reg)
        else $error("samples used out of range");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> load_fraction <= FULL_LOAD)
        else $error("load fraction above full load");

    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && state_reg == BK_IDLE)
        else $error("result load did not complete");
`endif

endmodule

// ----- hw/rtl/windowed_busy_load_average.sv -----
// Windowed busy-load monitor.
// Input channel (in_valid/in_stall, busy_req): one transaction per time tick,
// accepted at most once per cycle. Every sample_period ticks the period closes
// and its busy count is queued for the back end; other ticks give no result.
// Output channel (out_valid/out_stall): one transaction per closed period with
// load_fraction (Q1.16, saturated at 65536), samples_used and period_busy.
// Config port (cfg_we, cfg_index, cfg_wdata): index 0 window_select, index 1
// sample_period. Write only while the block is idle.
// Path from the closing tick to the result while the window length is
// unchanged: ring read and write, one multiply, a 16-step restoring divider.
// After a window change the window sum is rebuilt from the ring, one entry
// per cycle.
// Throughput: one tick per cycle while the 4-entry sample queue has room; the
// back end works on one closed period at a time until its result is loaded.
// Reset clears the tick counters, ring pointers, sum and output valid flag;
// window_select returns to 0 and sample_period to 2000.
// A stalled result holds in the output register; ticks keep being accepted
// until the sample queue fills, then in_stall rises.
module windowed_busy_load_average
    import wbla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                busy_req,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FRAC_W-1:0]   load_fraction,
    output logic [CNT_W-1:0]    samples_used,
    output logic [SAMPLE_W-1:0] period_busy
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t pop_item;

    wbla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .busy_req  (busy_req),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    wbla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    wbla_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .load_fraction (load_fraction),
        .samples_used  (samples_used),
        .period_busy   (period_busy)
    );

endmodule
